// File: hdl/qoi_enc_pkg.sv
// qoi encoder package: pixel type, chunk opcodes and index hash
package qoi_enc_pkg;

   localparam int INDEX_ENTRIES = 64;
   localparam int IDX_W         = $clog2(INDEX_ENTRIES);
   localparam int RUN_LIMIT     = 62;
   localparam int CHUNK_MAX     = 6;
   localparam int END_BYTES     = 8;

   localparam logic [7:0] OP_INDEX = 8'h00;
   localparam logic [7:0] OP_DIFF  = 8'h40;
   localparam logic [7:0] OP_LUMA  = 8'h80;
   localparam logic [7:0] OP_RUN   = 8'hC0;
   localparam logic [7:0] OP_RGB   = 8'hFE;
   localparam logic [7:0] OP_RGBA  = 8'hFF;

   localparam logic [7:0] END_LAST_BYTE = 8'h01;
   localparam logic [2:0] CHANNELS_RGB  = 3'd3;
   localparam logic [2:0] CHANNELS_RESET = 3'd4;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } pixel_type;

   localparam pixel_type PIXEL_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'hFF};

   function automatic logic [IDX_W-1:0] qoi_hash(pixel_type p);
      logic [12:0] s;
      s = 13'(p.r) * 13'd3 + 13'(p.g) * 13'd5 + 13'(p.b) * 13'd7 + 13'(p.a) * 13'd11;
      return s[IDX_W-1:0];
   endfunction

endpackage

// File: hdl/qoi_image_encoder.sv
// qoi chunk encoder top level: index memory, chunk selection and byte serializer
//
// one rgba pixel per req beat in raster order, req_final_pixel marks the last
// pixel of an image; chunk bytes leave one per rsp beat, rsp_last_of_run high
// on the last byte a pixel causes. a pixel that extends a run yields no beat
// unless the run reaches its limit or it is the last pixel. a pixel is taken
// into a hold register and its index entry is read from a 64 x 32 synchronous
// memory into rd_ff; it is then coded, and once the packet register is free
// the memory is written back and state updated; a write forwarded to the
// read of the pixel right behind it covers a hash collision. the coded bytes
// sit in a packet register drained one byte per cycle while rsp is not
// stalled; a pixel's byte count is 0 to 6, plus 8 end bytes on the last pixel.
// a new pixel is taken while the packet register still drains.
// reset, and the last pixel of an image, clear previous pixel, run count and
// the index valid bits at once; channel_count resets to 4.
// a stall on rsp holds the current byte; once the packet and hold register
// are full req_stall rises. channel_count is to be written through the csr
// port only while idle; the block itself does not enforce this.
module qoi_image_encoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_alpha,
   input  logic                   req_final_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_code_byte,
   output logic                   rsp_last_of_run,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [1:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import qoi_enc_pkg::*;

   logic [2:0]                chan_ff;
   logic                      s1_valid_ff, s1_valid_in;
   pixel_type                 s1_px_ff;
   logic [IDX_W-1:0]          s1_hash_ff;
   logic                      s1_last_ff;
   pixel_type                 prev_ff, prev_in;
   logic [IDX_W-1:0]          run_ff, run_in;
   logic [INDEX_ENTRIES-1:0]  valid_ff, valid_in;
   logic [31:0]               mem [INDEX_ENTRIES];
   logic [31:0]               rd_ff;
   logic                      fwd_valid_ff;
   logic [IDX_W-1:0]          fwd_addr_ff;
   pixel_type                 fwd_data_ff;
   logic                      pk_valid_ff, pk_valid_in;
   logic [7:0]                pk_bytes_ff [CHUNK_MAX];
   logic [2:0]                pk_count_ff;
   logic [3:0]                pk_total_ff;
   logic [3:0]                pk_idx_ff, pk_idx_in;

   logic                      accept;
   pixel_type                 in_px;
   logic [IDX_W-1:0]          in_hash;
   logic [IDX_W-1:0]          rd_addr;
   logic                      s1_fire;
   logic                      out_fire;
   logic                      pk_done;
   logic                      pk_free;
   logic                      wr_en;
   pixel_type                 entry;
   logic [7:0]                bytes [CHUNK_MAX];
   logic [2:0]                count;
   logic [3:0]                total;

   // input side
   always_comb begin
      in_px.r = req_red;
      in_px.g = req_green;
      in_px.b = req_blue;
      in_px.a = (chan_ff == CHANNELS_RGB) ? 8'hFF : req_alpha;
      in_hash = qoi_hash(in_px);
   end

   assign out_fire  = pk_valid_ff && !rsp_stall;
   assign pk_done   = out_fire && (pk_idx_ff == pk_total_ff - 4'd1);
   assign pk_free   = !pk_valid_ff || pk_done;
   assign s1_fire   = s1_valid_ff && pk_free;
   assign req_stall = s1_valid_ff && !pk_free;
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = accept ? in_hash : s1_hash_ff;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= in_px;
         s1_hash_ff <= in_hash;
         s1_last_ff <= req_final_pixel;
      end
      rd_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[s1_hash_ff] <= s1_px_ff;
      end
      fwd_addr_ff <= s1_hash_ff;
      fwd_data_ff <= s1_px_ff;
   end

   // coding stage
   always_comb begin
      logic              same;
      logic              match;
      logic [IDX_W-1:0]  run_inc;
      logic              run_emit;
      logic [7:0]        run_byte;
      logic [7:0]        chunk [CHUNK_MAX];
      logic [2:0]        ccnt;
      logic [7:0]        vr, vg, vb, dr, db;
      logic [7:0]        vr2, vg2, vb2, vg32, dr8, db8;

      entry = '0;
      if (valid_ff[s1_hash_ff]) begin
         entry = (fwd_valid_ff && fwd_addr_ff == s1_hash_ff) ? fwd_data_ff : pixel_type'(rd_ff);
      end
      same    = (s1_px_ff == prev_ff);
      match   = (entry == s1_px_ff);
      run_inc = run_ff + 1'b1;
      vr   = s1_px_ff.r - prev_ff.r;
      vg   = s1_px_ff.g - prev_ff.g;
      vb   = s1_px_ff.b - prev_ff.b;
      dr   = vr - vg;
      db   = vb - vg;
      vr2  = vr + 8'd2;
      vg2  = vg + 8'd2;
      vb2  = vb + 8'd2;
      vg32 = vg + 8'd32;
      dr8  = dr + 8'd8;
      db8  = db + 8'd8;

      for (int i = 0; i < CHUNK_MAX; i++) begin
         chunk[i] = '0;
      end
      ccnt = '0;
      if (match) begin
         chunk[0] = OP_INDEX | {2'b00, s1_hash_ff};
         ccnt     = 3'd1;
      end else if (s1_px_ff.a == prev_ff.a) begin
         if (vr2 < 8'd4 && vg2 < 8'd4 && vb2 < 8'd4) begin
            chunk[0] = OP_DIFF | {2'b00, vr2[1:0], vg2[1:0], vb2[1:0]};
            ccnt     = 3'd1;
         end else if (dr8 < 8'd16 && vg32 < 8'd64 && db8 < 8'd16) begin
            chunk[0] = OP_LUMA | {2'b00, vg32[5:0]};
            chunk[1] = {dr8[3:0], db8[3:0]};
            ccnt     = 3'd2;
         end else begin
            chunk[0] = OP_RGB;
            chunk[1] = s1_px_ff.r;
            chunk[2] = s1_px_ff.g;
            chunk[3] = s1_px_ff.b;
            ccnt     = 3'd4;
         end
      end else begin
         chunk[0] = OP_RGBA;
         chunk[1] = s1_px_ff.r;
         chunk[2] = s1_px_ff.g;
         chunk[3] = s1_px_ff.b;
         chunk[4] = s1_px_ff.a;
         ccnt     = 3'd5;
      end

      if (same) begin
         run_emit = (run_inc == IDX_W'(RUN_LIMIT)) || s1_last_ff;
         run_byte = OP_RUN | {2'b00, run_ff};
         ccnt     = '0;
         run_in   = run_emit ? '0 : run_inc;
      end else begin
         run_emit = (run_ff != '0);
         run_byte = OP_RUN | {2'b00, run_ff - 1'b1};
         run_in   = '0;
      end
      wr_en = s1_fire && !same && !match;

      bytes[0] = run_emit ? run_byte : chunk[0];
      for (int i = 1; i < CHUNK_MAX; i++) begin
         bytes[i] = run_emit ? chunk[i-1] : chunk[i];
      end
      count = ccnt + {2'b00, run_emit};
      total = {1'b0, count} + (s1_last_ff ? 4'(END_BYTES) : 4'd0);

      prev_in  = s1_last_ff ? PIXEL_RESET : s1_px_ff;
      valid_in = valid_ff;
      if (s1_last_ff) begin
         valid_in = '0;
         run_in   = '0;
      end else if (wr_en) begin
         valid_in[s1_hash_ff] = 1'b1;
      end
   end

   // packet register and byte serializer
   always_comb begin
      pk_valid_in = pk_valid_ff && !pk_done;
      pk_idx_in   = out_fire ? pk_idx_ff + 4'd1 : pk_idx_ff;
      if (s1_fire && total != '0) begin
         pk_valid_in = 1'b1;
         pk_idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && total != '0) begin
         pk_bytes_ff <= bytes;
         pk_count_ff <= count;
         pk_total_ff <= total;
      end
   end

   always_comb begin
      rsp_valid       = pk_valid_ff;
      rsp_last_of_run = (pk_idx_ff == pk_total_ff - 4'd1);
      if (pk_idx_ff < {1'b0, pk_count_ff}) begin
         rsp_code_byte = pk_bytes_ff[pk_idx_ff[2:0]];
      end else begin
         rsp_code_byte = rsp_last_of_run ? END_LAST_BYTE : 8'h00;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= CHANNELS_RESET;
         s1_valid_ff  <= 1'b0;
         prev_ff      <= PIXEL_RESET;
         run_ff       <= '0;
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
         pk_valid_ff  <= 1'b0;
         pk_idx_ff    <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == REG_CHANNEL_COUNT) begin
            chan_ff <= csr_pwdata[2:0];
         end
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= wr_en;
         pk_valid_ff  <= pk_valid_in;
         pk_idx_ff    <= pk_idx_in;
         if (s1_fire) begin
            prev_ff  <= prev_in;
            run_ff   <= run_in;
            valid_ff <= valid_in;
         end
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = {29'd0, chan_ff};

`ifndef NO_ASSERTIONS
   a_stall_needs_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && pk_valid_ff)
      else $error("req stalled without a held pixel and a busy packet");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff < IDX_W'(RUN_LIMIT))
      else $error("run count reached the run limit");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> valid_ff == '0 && run_ff == '0)
      else $error("index or run not cleared after the last pixel");

   a_packet_bounds: assert property (@(posedge clock) disable iff (reset)
      pk_valid_ff |-> pk_total_ff != '0 && pk_idx_ff < pk_total_ff)
      else $error("serializer index outside the packet");
`endif

endmodule

// File: tb/testbench.sv
// qoi_image_encoder testbench: pixel stimulus, chunk byte prediction and beat checking
`timescale 1ns / 100ps

module testbench;
   import qoi_enc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } chunk_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic [7:0]  req_alpha;
   logic        req_final_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_code_byte;
   logic        rsp_last_of_run;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   qoi_image_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .req_final_pixel (req_final_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_byte   (rsp_code_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   chunk_beat_type chunk_bytes_due[$];
   pixel_type   prev_pixel;
   pixel_type   color_table[INDEX_ENTRIES];
   int          run_count;
   logic [2:0]  channel_count;

   pixel_type   last_sent;
   pixel_type   recent_pixels[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_left;
   int          mismatch_count;
   int          beat_count;
   int          cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s at beat %0d: got %0h want %0h", what, beat_count, got, want);
      mismatch_count++;
   endtask

   function automatic void clear_encoder_state();
      prev_pixel = PIXEL_RESET;
      run_count  = 0;
      foreach (color_table[i]) color_table[i] = '0;
   endfunction

   function automatic void encode_pixel(pixel_type raw, logic fin);
      pixel_type         p;
      logic [7:0]        bytes[$];
      logic [5:0]        slot;
      logic signed [7:0] vr, vg, vb, dr, db;
      chunk_beat_type    beat;
      p = raw;
      if (channel_count == CHANNELS_RGB) p.a = 8'hFF;
      if (p == prev_pixel) begin
         run_count++;
         if (run_count == RUN_LIMIT || fin) begin
            bytes.push_back(OP_RUN | 8'(run_count - 1));
            run_count = 0;
         end
      end else begin
         slot = 6'(int'(p.r) * 3 + int'(p.g) * 5 + int'(p.b) * 7 + int'(p.a) * 11);
         if (run_count > 0) begin
            bytes.push_back(OP_RUN | 8'(run_count - 1));
            run_count = 0;
         end
         if (color_table[slot] == p) begin
            bytes.push_back(OP_INDEX | 8'(slot));
         end else begin
            color_table[slot] = p;
            if (p.a == prev_pixel.a) begin
               vr = p.r - prev_pixel.r;
               vg = p.g - prev_pixel.g;
               vb = p.b - prev_pixel.b;
               dr = vr - vg;
               db = vb - vg;
               if (vr >= -2 && vr <= 1 && vg >= -2 && vg <= 1 && vb >= -2 && vb <= 1) begin
                  bytes.push_back(OP_DIFF | 8'(((vr + 2) << 4) | ((vg + 2) << 2) | (vb + 2)));
               end else if (dr >= -8 && dr <= 7 && vg >= -32 && vg <= 31 &&
                            db >= -8 && db <= 7) begin
                  bytes.push_back(OP_LUMA | 8'(vg + 32));
                  bytes.push_back(8'(((dr + 8) << 4) | (db + 8)));
               end else begin
                  bytes.push_back(OP_RGB);
                  bytes.push_back(p.r);
                  bytes.push_back(p.g);
                  bytes.push_back(p.b);
               end
            end else begin
               bytes.push_back(OP_RGBA);
               bytes.push_back(p.r);
               bytes.push_back(p.g);
               bytes.push_back(p.b);
               bytes.push_back(p.a);
            end
         end
      end
      prev_pixel = p;
      if (fin) begin
         repeat (END_BYTES - 1) bytes.push_back(8'h00);
         bytes.push_back(END_LAST_BYTE);
         clear_encoder_state();
      end
      foreach (bytes[i]) begin
         beat.code = bytes[i];
         beat.last = (i == bytes.size() - 1);
         chunk_bytes_due.push_back(beat);
      end
   endfunction

   task automatic send_pixel(pixel_type p, logic fin);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red         <= p.r;
      req_green       <= p.g;
      req_blue        <= p.b;
      req_alpha       <= p.a;
      req_final_pixel <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_pixel(p, fin);
      last_sent = p;
      recent_pixels.push_back(p);
      if (recent_pixels.size() > 16) void'(recent_pixels.pop_front());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (chunk_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_channels(logic [2:0] value);
      logic [31:0] readback;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 2'(4 * REG_CHANNEL_COUNT);
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      channel_count = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[2:0] != value) report_mismatch("channel_count readback", readback, value);
   endtask

   function automatic pixel_type make_pixel(int r, int g, int b, int a);
      pixel_type p;
      p.r = 8'(r);
      p.g = 8'(g);
      p.b = 8'(b);
      p.a = 8'(a);
      return p;
   endfunction

   function automatic pixel_type next_pixel();
      pixel_type p;
      int        kind;
      int        vg;
      kind = $urandom_range(99);
      p = last_sent;
      if (kind < 30) begin
         p = last_sent;
      end else if (kind < 45 && recent_pixels.size() > 0) begin
         p = recent_pixels[$urandom_range(recent_pixels.size() - 1)];
      end else if (kind < 65) begin
         p.r = last_sent.r + 8'($urandom_range(3)) - 8'd2;
         p.g = last_sent.g + 8'($urandom_range(3)) - 8'd2;
         p.b = last_sent.b + 8'($urandom_range(3)) - 8'd2;
      end else if (kind < 80) begin
         vg = int'($urandom_range(63)) - 32;
         p.g = last_sent.g + 8'(vg);
         p.r = last_sent.r + 8'(vg + int'($urandom_range(15)) - 8);
         p.b = last_sent.b + 8'(vg + int'($urandom_range(15)) - 8);
      end else if (kind < 90) begin
         {p.r, p.g, p.b} = 24'($urandom);
      end else begin
         p = $urandom;
      end
      return p;
   endfunction

   task automatic test_chunk_types();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_pixel(make_pixel(0, 0, 0, 255), 1'b0);
      send_pixel(make_pixel(0, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(1, 0, 255, 0), 1'b0);
      send_pixel(make_pixel(255, 255, 255, 0), 1'b0);
      send_pixel(make_pixel(20, 20, 20, 0), 1'b0);
      send_pixel(make_pixel(30, 52, 74, 0), 1'b0);
      send_pixel(make_pixel(61, 83, 105, 0), 1'b0);
      send_pixel(make_pixel(60, 115, 130, 0), 1'b0);
      send_pixel(make_pixel(255, 255, 255, 255), 1'b0);
      send_pixel(make_pixel(0, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(1, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(65, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(1, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(0, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(0, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(0, 0, 0, 0), 1'b1);
      send_pixel(make_pixel(0, 0, 0, 255), 1'b1);
      send_pixel(make_pixel(128, 127, 1, 128), 1'b0);
      send_pixel(make_pixel(0, 0, 0, 0), 1'b0);
      send_pixel(make_pixel(7, 7, 7, 7), 1'b0);
      send_pixel(make_pixel(7, 7, 7, 7), 1'b0);
      send_pixel(make_pixel(200, 100, 50, 25), 1'b1);
      send_pixel(make_pixel(170, 85, 240, 15), 1'b1);
      wait_drained();
   endtask

   task automatic test_long_run();
      send_pixel(make_pixel(9, 9, 9, 9), 1'b0);
      repeat (140) send_pixel(make_pixel(9, 9, 9, 9), 1'b0);
      send_pixel(make_pixel(9, 9, 9, 9), 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      pixel_type p;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left <= 300;
      repeat (24) begin
         p = $urandom;
         p.a = last_sent.a ^ 8'h5A;
         send_pixel(p, 1'b0);
      end
      wait_drained();
   endtask

   task automatic test_random_images();
      int         idle_mode[4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{35, 35}};
      logic [2:0] channel_plan[6] = '{3'd4, 3'd3, 3'd7, 3'd0, 3'd3, 3'd4};
      foreach (channel_plan[ph]) begin
         write_channels(channel_plan[ph]);
         send_idle_pct  = idle_mode[ph % 4][0];
         recv_stall_pct = idle_mode[ph % 4][1];
         repeat (25) send_pixel(next_pixel(), $urandom_range(29) == 0);
         wait_drained();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_pixel(next_pixel(), 1'b1);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin : check_beat
      chunk_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (chunk_bytes_due.size() == 0) begin
            report_mismatch("beat with nothing due", rsp_code_byte, 0);
         end else begin
            want = chunk_bytes_due.pop_front();
            if (rsp_code_byte !== want.code)
               report_mismatch("code_byte", rsp_code_byte, want.code);
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", rsp_last_of_run, want.last);
         end
         beat_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("qoi_image_encoder regression: fail");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      req_alpha       = '0;
      req_final_pixel = 1'b0;
      rsp_stall       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      hold_left       = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      mismatch_count  = 0;
      beat_count      = 0;
      cycle_count     = 0;
      channel_count   = CHANNELS_RESET;
      last_sent       = PIXEL_RESET;
      clear_encoder_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_chunk_types();
      test_long_run();
      test_backpressure();
      test_random_images();

      if (mismatch_count == 0) begin
         $display("qoi_image_encoder regression: pass");
      end else begin
         $display("qoi_image_encoder regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/qoi_enc_pkg.sv
hdl/qoi_image_encoder.sv
tb/testbench.sv
